FILE: hdl/lvs_pkg.sv
// Package: command codes, register indexes and item types for the Lehmer sampler.
package lvs_pkg;

	localparam int TableDepth = 16;
	localparam int IdxW = $clog2(TableDepth);

	typedef enum logic [2:0] {
		CMD_UNIFORM = 3'd0,
		CMD_BERN    = 3'd1,
		CMD_BINOM   = 3'd2,
		CMD_DISC    = 3'd3,
		CMD_LOAD    = 3'd4,
		CMD_RESEED  = 3'd5
	} cmd_t;

	localparam logic [1:0] REG_SEED  = 2'd0;
	localparam logic [1:0] REG_MULT  = 2'd1;
	localparam logic [1:0] REG_MOD   = 2'd2;
	localparam logic [1:0] REG_TSIZE = 2'd3;

	typedef struct packed {
		logic [2:0]         cmd;
		logic [32:0]        prob_fraction;
		logic [15:0]        trial_count;
		logic [3:0]         entry_index;
		logic signed [31:0] entry_value;
	} in_item_t;

	typedef struct packed {
		logic [31:0]        uniform_fraction;
		logic [15:0]        success_count;
		logic signed [31:0] chosen_value;
		logic [31:0]        generator_now;
	} out_item_t;

	// request to the bit-serial arithmetic unit
	typedef struct packed {
		logic        start;
		logic [31:0] a;
		logic [31:0] b;
		logic [32:0] m;
	} mm_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] r;
	} mm_rsp_t;

endpackage

FILE: hdl/lehmer_variate_sampler.sv
// Top level: Lehmer generator with uniform, Bernoulli, binomial and table draws.
// An item is taken when start is high and busy is low; its single result shows
// for one cycle with done. A uniform draw runs a 64-step bit-serial modular
// multiply (32 steps reduce the state mod m, 32 multiply), then a 64-step
// restoring divide for u. A Bernoulli draw adds a 33-step serial multiply for the
// exact compare of x*2^32 against p*m, then a decide state. A binomial repeats
// that per trial; a discrete draw adds a further compare for each table entry
// walked past the first. Loads, reseeds and unknown codes go straight to output.
// The receiver cannot stall.
module lehmer_variate_sampler (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  lvs_pkg::in_item_t  in_item,
	output logic              done,
	output lvs_pkg::out_item_t out_item,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_idx,
	input  logic [31:0]       cfg_data
);
	import lvs_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_MUL, S_MULW, S_DIV, S_CMP, S_DECIDE, S_NEXT, S_OUT
	} state_t;

	state_t state_q;

	logic [31:0] seed_q, mult_q, mod_q;
	logic [4:0]  tsize_q;
	logic [31:0] gen_q;
	logic [32:0] prob_q [TableDepth];
	logic [31:0] val_q  [TableDepth];

	in_item_t    item_q;
	logic [32:0] p_q;
	logic [15:0] trials_q;
	logic [15:0] succ_q;
	logic [31:0] frac_q;
	logic [31:0] chosen_q;
	logic [IdxW-1:0] ent_q;
	logic [IdxW-1:0] last_q;
	logic [33:0] cdf_q;

	// divide: quotient of x*2^32 / m, bit serial
	logic [32:0] rem_q;
	logic [31:0] quo_q;
	logic [63:0] dsh_q;
	// compare: p*m built serially, then compared to x*2^32
	logic [65:0] pm_q;
	logic [32:0] pmul_q;
	logic [32:0] mcand_q;
	logic [5:0]  cnt_q;

	mm_req_t req;
	mm_rsp_t rsp;

	logic [32:0] mod_eff;
	logic [33:0] rsh;
	logic        dge;
	logic [32:0] psat;
	logic [33:0] cdf_nxt;
	logic [32:0] cdf_sat;
	logic [64:0] lhs;
	logic        lt, eq;
	logic [4:0]  ncnt;

	assign mod_eff = (mod_q == '0) ? 33'h1_0000_0000 : {1'b0, mod_q};
	assign rsh     = {rem_q, dsh_q[63]};
	assign dge     = (rsh >= {1'b0, mod_eff});
	assign psat    = (prob_q[ent_q] > 33'h1_0000_0000) ? 33'h1_0000_0000 : prob_q[ent_q];
	assign cdf_nxt = cdf_q + {1'b0, psat};
	assign cdf_sat = (cdf_nxt > 34'h1_0000_0000) ? 33'h1_0000_0000 : cdf_nxt[32:0];
	assign lhs     = {1'b0, gen_q, 32'd0};
	assign lt      = (pmul_q >= 33'h1_0000_0000) || (lhs < pm_q[64:0]);
	assign eq      = (pmul_q < 33'h1_0000_0000) && (lhs == pm_q[64:0]);
	assign ncnt    = (tsize_q == 5'd0) ? 5'd1 :
		(tsize_q > 5'(TableDepth)) ? 5'(TableDepth) : tsize_q;

	assign busy = (state_q != S_IDLE);

	lvs_modmul u_mm (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always_comb begin
		req.start = (state_q == S_MUL);
		req.a     = gen_q;
		req.b     = mult_q;
		req.m     = mod_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done    <= 1'b0;
			seed_q  <= 32'd1;
			mult_q  <= 32'd16807;
			mod_q   <= 32'd2147483647;
			tsize_q <= 5'd1;
			gen_q   <= 32'd1;
			for (int i = 0; i < TableDepth; i++) begin
				prob_q[i] <= '0;
				val_q[i]  <= '0;
			end
		end else begin
			done <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_SEED:  seed_q  <= cfg_data;
					REG_MULT:  mult_q  <= cfg_data;
					REG_MOD:   mod_q   <= cfg_data;
					REG_TSIZE: tsize_q <= cfg_data[4:0];
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						item_q   <= in_item;
						p_q      <= (in_item.prob_fraction > 33'h1_0000_0000) ?
							33'h1_0000_0000 : in_item.prob_fraction;
						trials_q <= in_item.trial_count;
						succ_q   <= '0;
						frac_q   <= '0;
						chosen_q <= '0;
						ent_q    <= '0;
						last_q   <= IdxW'(ncnt - 5'd1);
						cdf_q    <= '0;
						case (in_item.cmd) inside
							CMD_UNIFORM, CMD_BERN, CMD_DISC: state_q <= S_MUL;
							CMD_BINOM: state_q <= (in_item.trial_count != '0) ? S_MUL : S_OUT;
							CMD_LOAD: begin
								prob_q[in_item.entry_index] <= in_item.prob_fraction;
								val_q[in_item.entry_index]  <= in_item.entry_value;
								state_q <= S_OUT;
							end
							CMD_RESEED: begin
								gen_q   <= seed_q;
								state_q <= S_OUT;
							end
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_MUL: state_q <= S_MULW;
				S_MULW: begin
					if (rsp.done) begin
						gen_q   <= rsp.r;
						rem_q   <= '0;
						quo_q   <= '0;
						dsh_q   <= {rsp.r, 32'd0};
						cnt_q   <= 6'd0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (dge) begin
						rem_q <= 33'(rsh - {1'b0, mod_eff});
						quo_q <= {quo_q[30:0], 1'b1};
					end else begin
						rem_q <= rsh[32:0];
						quo_q <= {quo_q[30:0], 1'b0};
					end
					dsh_q <= {dsh_q[62:0], 1'b0};
					// wraps to zero after the last step, ready for the compare
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						frac_q <= (mod_q == '0) ? gen_q : {quo_q[30:0], dge};
						if (item_q.cmd == CMD_UNIFORM) begin
							state_q <= S_OUT;
						end else begin
							pmul_q  <= (item_q.cmd == CMD_DISC) ? cdf_sat : p_q;
							if (item_q.cmd == CMD_DISC) cdf_q <= {1'b0, cdf_sat};
							mcand_q <= mod_eff;
							pm_q    <= '0;
							state_q <= S_CMP;
						end
					end
				end
				S_CMP: begin
					pm_q  <= {pm_q[64:0], 1'b0} + (pmul_q[6'd32 - cnt_q] ?
						{33'd0, mcand_q} : 66'd0);
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd32) state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					case (item_q.cmd)
						CMD_BERN: begin
							succ_q  <= (lt || eq) ? 16'd1 : 16'd0;
							state_q <= S_OUT;
						end
						CMD_BINOM: begin
							if (lt) succ_q <= succ_q + 16'd1;
							trials_q <= trials_q - 16'd1;
							state_q  <= (trials_q != 16'd1) ? S_MUL : S_OUT;
						end
						default: begin
							if (lt || eq) begin
								chosen_q <= val_q[ent_q];
								state_q  <= S_OUT;
							end else if (ent_q == last_q) begin
								chosen_q <= val_q[last_q];
								state_q  <= S_OUT;
							end else begin
								ent_q   <= ent_q + 1'b1;
								state_q <= S_NEXT;
							end
						end
					endcase
				end
				S_NEXT: begin
					pmul_q  <= cdf_sat;
					cdf_q   <= {1'b0, cdf_sat};
					pm_q    <= '0;
					cnt_q   <= 6'd0;
					state_q <= S_CMP;
				end
				S_OUT: begin
					done     <= 1'b1;
					out_item.uniform_fraction <= frac_q;
					out_item.success_count    <= succ_q;
					out_item.chosen_value     <= chosen_q;
					out_item.generator_now    <= gen_q;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$past(done)) else $error("two results back to back");
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("busy with result");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("item not taken");

endmodule

FILE: hdl/lvs_modmul.sv
// Bit-serial modular multiplier: r = (a*b) mod m, a reduced first, then one multiplier bit per cycle.
module lvs_modmul (
	input  logic            clk,
	input  logic            arst_n,
	input  lvs_pkg::mm_req_t req,
	output lvs_pkg::mm_rsp_t rsp
);
	import lvs_pkg::*;

	logic [31:0] b_q;
	logic [31:0] ash_q;
	logic [32:0] acc_q;
	logic [32:0] a_q;
	logic [32:0] m_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        red_q;
	logic        done_q;
	logic [31:0] r_q;
	logic [33:0] rsh;
	logic [33:0] rred;
	logic [33:0] dbl;
	logic [33:0] dred;
	logic [33:0] add;
	logic [33:0] ared;

	always_comb begin
		// reduce phase: shift a in msb first, keep the remainder below m
		rsh  = {acc_q, ash_q[31]};
		rred = (rsh >= {1'b0, m_q}) ? rsh - {1'b0, m_q} : rsh;
		dbl  = {acc_q, 1'b0};
		dred = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
		add  = b_q[31] ? dred + {1'b0, a_q} : dred;
		ared = (add >= {1'b0, m_q}) ? add - {1'b0, m_q} : add;
	end

	assign rsp = '{done: done_q, r: r_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			red_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				red_q  <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				if (cnt_q == 6'd1) begin
					cnt_q <= 6'd32;
					red_q <= 1'b0;
					if (!red_q) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			ash_q <= req.a;
			b_q   <= req.b;
			m_q   <= req.m;
			acc_q <= '0;
		end else if (busy_q && red_q) begin
			ash_q <= {ash_q[30:0], 1'b0};
			if (cnt_q == 6'd1) begin
				a_q   <= rred[32:0];
				acc_q <= '0;
			end else begin
				acc_q <= rred[32:0];
			end
		end else if (busy_q) begin
			acc_q <= ared[32:0];
			b_q   <= {b_q[30:0], 1'b0};
		end
		r_q <= ared[31:0];
	end

endmodule

FILE: sim/lehmer_variate_sampler_tb.sv
// Testbench for lehmer_variate_sampler: directed and random items checked against a predictor.
module lehmer_variate_sampler_tb;
	import lvs_pkg::*;

	localparam logic [2:0] CMD_SPARE_LO = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;
	localparam logic [32:0] P_ONE = 33'h1_0000_0000;
	localparam int CYCLE_LIMIT = 80000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	in_item_t in_item = '0;
	logic done;
	out_item_t out_item;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_idx = '0;
	logic [31:0] cfg_data = '0;

	// predictor copy of registers and state
	logic [31:0] seed_r, mult_r, mod_r;
	logic [4:0] tsize_r;
	logic [31:0] gen_x;
	logic [32:0] prob_mem [TableDepth];
	logic [31:0] val_mem [TableDepth];

	out_item_t expected_q [$];
	int errors = 0;
	int cycles = 0;
	int gap_pct = 0;

	lehmer_variate_sampler u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in_item(in_item),
		.done(done), .out_item(out_item), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic logic [31:0] lcg_advance();
		logic [63:0] prod;
		prod = {32'd0, gen_x} * {32'd0, mult_r};
		gen_x = (mod_r == 0) ? prod[31:0] : 32'(prod % {32'd0, mod_r});
		return gen_x;
	endfunction

	function automatic logic [31:0] q32_of(logic [31:0] x);
		logic [63:0] num;
		num = {x, 32'd0};
		return (mod_r == 0) ? x : 32'(num / {32'd0, mod_r});
	endfunction

	function automatic logic [32:0] clamp_p(logic [33:0] p);
		return (p > P_ONE) ? P_ONE : p[32:0];
	endfunction

	// sign of x*2^32 - p*m
	function automatic int cmp_scaled(logic [31:0] x, logic [32:0] p);
		logic [63:0] lhs, rhs;
		if (p >= P_ONE) return -1;
		lhs = {x, 32'd0};
		rhs = (mod_r == 0) ? {p[31:0], 32'd0} : {32'd0, p[31:0]} * {32'd0, mod_r};
		if (lhs < rhs) return -1;
		return (lhs == rhs) ? 0 : 1;
	endfunction

	function automatic out_item_t sample_outcome(in_item_t it);
		out_item_t r;
		logic [32:0] p;
		logic [31:0] x;
		logic [32:0] cdf;
		int n;
		r = '0;
		p = clamp_p({1'b0, it.prob_fraction});
		case (it.cmd)
			CMD_UNIFORM: r.uniform_fraction = q32_of(lcg_advance());
			CMD_BERN: begin
				x = lcg_advance();
				r.uniform_fraction = q32_of(x);
				r.success_count = (cmp_scaled(x, p) <= 0) ? 16'd1 : 16'd0;
			end
			CMD_BINOM: begin
				for (int i = 0; i < it.trial_count; i++) begin
					x = lcg_advance();
					r.uniform_fraction = q32_of(x);
					if (cmp_scaled(x, p) < 0) r.success_count++;
				end
			end
			CMD_DISC: begin
				n = (tsize_r == 0) ? 1 : (tsize_r > TableDepth) ? TableDepth : tsize_r;
				x = lcg_advance();
				r.uniform_fraction = q32_of(x);
				cdf = '0;
				r.chosen_value = val_mem[n-1];
				for (int i = 0; i < n; i++) begin
					cdf = clamp_p({1'b0, cdf} + {1'b0, clamp_p({1'b0, prob_mem[i]})});
					if (cmp_scaled(x, cdf) <= 0) begin
						r.chosen_value = val_mem[i];
						break;
					end
				end
			end
			CMD_LOAD: begin
				prob_mem[it.entry_index] = it.prob_fraction;
				val_mem[it.entry_index] = it.entry_value;
			end
			CMD_RESEED: gen_x = seed_r;
			default: ;
		endcase
		r.generator_now = gen_x;
		return r;
	endfunction

	always @(posedge clk) begin
		out_item_t e;
		if (done) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected item %h", $time, out_item);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (out_item.uniform_fraction !== e.uniform_fraction) begin
					$display("%0t: uniform_fraction exp %h got %h", $time,
						e.uniform_fraction, out_item.uniform_fraction);
					errors++;
				end
				if (out_item.success_count !== e.success_count) begin
					$display("%0t: success_count exp %0d got %0d", $time,
						e.success_count, out_item.success_count);
					errors++;
				end
				if (out_item.chosen_value !== e.chosen_value) begin
					$display("%0t: chosen_value exp %0d got %0d", $time,
						e.chosen_value, out_item.chosen_value);
					errors++;
				end
				if (out_item.generator_now !== e.generator_now) begin
					$display("%0t: generator_now exp %h got %h", $time,
						e.generator_now, out_item.generator_now);
					errors++;
				end
			end
		end
	end

	// called at a rising edge; returns at the edge that accepts the item
	task automatic send_item(in_item_t it);
		while ($urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		in_item <= it;
		do @(negedge clk); while (busy);
		@(posedge clk);
		expected_q.push_back(sample_outcome(it));
	endtask

	task automatic drain();
		start <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		case (idx)
			REG_SEED: seed_r = data;
			REG_MULT: mult_r = data;
			REG_MOD: mod_r = data;
			REG_TSIZE: tsize_r = data[4:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic in_item_t make_item(logic [2:0] c, logic [32:0] p, logic [15:0] t,
			logic [3:0] ix, logic [31:0] v);
		in_item_t it;
		it.cmd = c;
		it.prob_fraction = p;
		it.trial_count = t;
		it.entry_index = ix;
		it.entry_value = v;
		return it;
	endfunction

	function automatic logic [32:0] rand_prob();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return P_ONE;
			2: return {1'b1, 32'($urandom)};
			3: return 33'($urandom_range(0, 32'h3000_0000));
			default: return {1'b0, 32'($urandom)};
		endcase
	endfunction

	function automatic in_item_t rand_item();
		int r;
		logic [2:0] c;
		logic [15:0] t;
		r = $urandom_range(0, 99);
		c = (r < 15) ? CMD_UNIFORM : (r < 30) ? CMD_BERN : (r < 45) ? CMD_BINOM :
			(r < 65) ? CMD_DISC : (r < 85) ? CMD_LOAD : (r < 92) ? CMD_RESEED :
			(r < 96) ? CMD_SPARE_LO : CMD_SPARE_HI;
		t = 16'($urandom);
		if (c == CMD_BINOM)
			t = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, 150))
				: 16'($urandom_range(0, 8));
		return make_item(c, rand_prob(), t, 4'($urandom), 32'($urandom));
	endfunction

	task automatic test_directed();
		send_item(make_item(CMD_UNIFORM, '1, 16'hFFFF, 4'hF, 32'hFFFF_FFFF));
		send_item(make_item(CMD_BERN, '0, 16'h0, 4'h0, 32'h0));
		send_item(make_item(CMD_BERN, P_ONE, 16'h0, 4'h0, 32'h0));
		send_item(make_item(CMD_BERN, '1, 16'h0, 4'h0, 32'h0));
		send_item(make_item(CMD_BINOM, 33'h0_8000_0000, 16'd0, 4'h0, 32'h0));
		send_item(make_item(CMD_BINOM, 33'h0_8000_0000, 16'd6, 4'h0, 32'h0));
		send_item(make_item(CMD_BINOM, '1, 16'd3, 4'h0, 32'h0));
		send_item(make_item(CMD_DISC, '0, 16'h0, 4'h0, 32'h0));
		send_item(make_item(CMD_LOAD, 33'h0_4000_0000, 16'h0, 4'd0, 32'h8000_0000));
		send_item(make_item(CMD_LOAD, '1, 16'h0, 4'd15, 32'h7FFF_FFFF));
		send_item(make_item(CMD_LOAD, 33'h0_C000_0000, 16'h0, 4'd1, 32'd5));
		send_item(make_item(CMD_DISC, '0, 16'h0, 4'h0, 32'h0));
		send_item(make_item(CMD_RESEED, '0, 16'h0, 4'h0, 32'h0));
		send_item(make_item(CMD_SPARE_LO, '1, 16'hFFFF, 4'hF, 32'hFFFF_FFFF));
		send_item(make_item(CMD_SPARE_HI, '1, 16'hFFFF, 4'hF, 32'hFFFF_FFFF));
		send_item(make_item(CMD_UNIFORM, '0, 16'h0, 4'h0, 32'h0));
		drain();
	endtask

	task automatic test_config_extremes();
		write_reg(REG_TSIZE, 32'd16);
		write_reg(REG_MOD, 32'd0);
		write_reg(REG_MULT, 32'hFFFF_FFFF);
		write_reg(REG_SEED, 32'hFFFF_FFFF);
		send_item(make_item(CMD_RESEED, '0, 16'h0, 4'h0, 32'h0));
		send_item(make_item(CMD_UNIFORM, '0, 16'h0, 4'h0, 32'h0));
		send_item(make_item(CMD_BERN, 33'h0_8000_0000, 16'h0, 4'h0, 32'h0));
		send_item(make_item(CMD_DISC, '0, 16'h0, 4'h0, 32'h0));
		drain();
		write_reg(REG_MOD, 32'd1);
		write_reg(REG_TSIZE, 32'd0);
		send_item(make_item(CMD_UNIFORM, '0, 16'h0, 4'h0, 32'h0));
		send_item(make_item(CMD_DISC, '0, 16'h0, 4'h0, 32'h0));
		drain();
		write_reg(REG_MOD, 32'hFFFF_FFFF);
		write_reg(REG_MULT, 32'd1);
		write_reg(REG_SEED, 32'd0);
		write_reg(REG_TSIZE, 32'hFFFF_FFFF);
		send_item(make_item(CMD_RESEED, '0, 16'h0, 4'h0, 32'h0));
		send_item(make_item(CMD_BINOM, 33'h0_0000_0001, 16'd4, 4'h0, 32'h0));
		send_item(make_item(CMD_DISC, '0, 16'h0, 4'h0, 32'h0));
		drain();
	endtask

	task automatic test_random_phases();
		int pct [4] = '{0, 81, 0, 8};
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(REG_SEED, 32'($urandom_range(1, 32'hFFFF_FFFF)));
			write_reg(REG_MULT, ($urandom_range(0, 1) != 0) ? 32'd16807 : 32'($urandom));
			write_reg(REG_MOD, ($urandom_range(0, 1) != 0) ? 32'd2147483647 : 32'($urandom));
			write_reg(REG_TSIZE, 32'($urandom_range(1, 16)));
			gap_pct = pct[ph];
			send_item(make_item(CMD_RESEED, '0, 16'h0, 4'h0, 32'h0));
			for (int k = 0; k < 150; k++) begin
				send_item(rand_item());
				if (k == 75) drain();
			end
			drain();
		end
	endtask

	initial begin
		seed_r = 32'd1;
		mult_r = 32'd16807;
		mod_r = 32'd2147483647;
		tsize_r = 5'd1;
		gen_x = 32'd1;
		for (int i = 0; i < TableDepth; i++) begin
			prob_mem[i] = '0;
			val_mem[i] = '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_extremes();
		test_random_phases();
		drain();
		repeat (40) @(posedge clk);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

FILE: filelist.f
hdl/lvs_pkg.sv
hdl/lvs_modmul.sv
hdl/lehmer_variate_sampler.sv
sim/lehmer_variate_sampler_tb.sv
